### src/cts_pkg.sv
package cts_pkg;

  // Default table depth and the per-dispatch run limit.
  localparam int MAX_TASKS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

  // Operation codes of a request.
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_DISPATCH = 2'd2;
  localparam logic [1:0] OP_DELETE   = 2'd3;

  // Result kinds.
  localparam logic [2:0] RK_ADDED      = 3'd0;
  localparam logic [2:0] RK_FULL       = 3'd1;
  localparam logic [2:0] RK_RUN        = 3'd2;
  localparam logic [2:0] RK_DELETED    = 3'd3;
  localparam logic [2:0] RK_BAD_SLOT   = 3'd4;
  localparam logic [2:0] RK_NONE_READY = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_handle;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] task_handle_out;
    logic [4:0] slot_out;
    logic       last;
  } rsp_t;

  // One table entry, held by one cell.
  typedef struct packed {
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_TICK,
    CMD_SHIFT,
    CMD_DEC
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    entry;
  } cell_ctrl_t;

endpackage

### src/cts_cell.sv
module cts_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cts_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       pos_i,
  input  logic [CW-1:0]       count_i,
  input  cts_pkg::entry_t     nbr_i,
  output cts_pkg::entry_t     entry_o
);

  cts_pkg::entry_t entry_q, entry_d;
  logic            live;
  logic            at_pos;
  logic            above_pos;

  // Position of this cell relative to the fill level and the cursor.
  assign live      = CW'(IDX) < count_i;
  assign at_pos    = CW'(IDX) == pos_i;
  assign above_pos = CW'(IDX) >= pos_i;

  // Local update of the held entry.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      cts_pkg::CMD_NONE: ;
      cts_pkg::CMD_ADD: begin
        if (CW'(IDX) == count_i) entry_d = ctrl_i.entry;
      end
      cts_pkg::CMD_TICK: begin
        if (live) begin
          if (entry_q.delay != 16'd0) begin
            entry_d.delay = entry_q.delay - 16'd1;
          end else begin
            entry_d.delay = entry_q.period;
            if (entry_q.pending != 8'hFF) entry_d.pending = entry_q.pending + 8'd1;
          end
        end
      end
      cts_pkg::CMD_SHIFT: begin
        // Entries at and above the removed slot move down by one.
        if (above_pos) entry_d = nbr_i;
      end
      cts_pkg::CMD_DEC: begin
        if (at_pos) entry_d.pending = entry_q.pending - 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

### src/cooperative_task_scheduler_table_top.sv
// Cooperative task table: a row of cells, one table entry per cell.
// Requests enter on req_valid_i/req_ready_o with payload req_i; results
// leave on res_valid_o/res_ready_i with payload res_o.
// req_ready_o is high while the block is idle, also while a result still
// waits in the output register.
// Add, delete and tick execute in the EXEC state after acceptance; the
// result of add or delete sits in the output register (tick gives none).
// A dispatch walks the table with a cursor that visits one cell per cycle
// while the output does not stall it; each step either advances the cursor
// or removes a one-shot entry, up to the fill level or the run limit.
// Run results are staged in a hold register so the final one can carry
// the last flag; kind "nothing ready" is sent when no entry ran.
// When the receiver stalls, the walk pauses at the next run result and
// resumes when the output register frees up; nothing is dropped.
// Reset clears every entry and the fill count at once, no sweep is needed.
module cooperative_task_scheduler_table_top #(
  parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cts_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output cts_pkg::rsp_t res_o
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NW = cts_pkg::NRES_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DISP = 2'd2;

  logic [1:0]          state_q, state_d;
  cts_pkg::req_t       req_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [NW-1:0]       nres_q, nres_d;
  cts_pkg::rsp_t       hold_q, hold_d;
  logic                hold_valid_q, hold_valid_d;
  cts_pkg::rsp_t       out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                out_free;

  cts_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]       cell_pos;
  cts_pkg::entry_t     ent [MAX_TASKS+1];
  cts_pkg::entry_t     sel;
  logic                req_fire;
  logic                slot_bad;
  logic                table_full;
  logic                scan;

  assign req_ready_o = (state_q == ST_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign out_free    = !out_valid_q || res_ready_i;
  assign table_full  = (count_q == CW'(MAX_TASKS));
  assign slot_bad    = 8'(req_q.slot_index) >= 8'(count_q);
  assign scan        = (pos_q < count_q) && (nres_q < NW'(cts_pkg::MAX_RESULTS));

  // The row of cells; the top cell shifts in an empty entry.
  assign ent[MAX_TASKS] = '0;
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    cts_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .nbr_i   (ent[g+1]),
      .entry_o (ent[g])
    );
  end

  // Cursor position seen by the cells: the delete slot or the dispatch cursor.
  assign cell_pos = (state_q == ST_EXEC) ? CW'(req_q.slot_index) : pos_q;

  // Read the entry under the cursor.
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (CW'(i) == cell_pos) sel = sel | ent[i];
    end
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    nres_d       = nres_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_load     = 1'b0;
    out_d        = out_q;
    ctrl.cmd     = cts_pkg::CMD_NONE;
    ctrl.entry   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q.operation)
          cts_pkg::OP_ADD: begin
            if (out_free) begin
              out_load                = 1'b1;
              out_d.task_handle_out   = req_q.task_handle;
              out_d.last              = 1'b1;
              if (table_full) begin
                out_d.result_kind = cts_pkg::RK_FULL;
                out_d.slot_out    = 5'(MAX_TASKS);
              end else begin
                out_d.result_kind    = cts_pkg::RK_ADDED;
                out_d.slot_out       = 5'(count_q);
                ctrl.cmd             = cts_pkg::CMD_ADD;
                ctrl.entry.handle    = req_q.task_handle;
                ctrl.entry.delay     = req_q.delay_ticks;
                ctrl.entry.period    = req_q.period_ticks;
                ctrl.entry.pending   = 8'd0;
                count_d              = count_q + CW'(1);
              end
              state_d = ST_IDLE;
            end
          end
          cts_pkg::OP_TICK: begin
            ctrl.cmd = cts_pkg::CMD_TICK;
            state_d  = ST_IDLE;
          end
          cts_pkg::OP_DISPATCH: begin
            pos_d        = '0;
            nres_d       = '0;
            hold_valid_d = 1'b0;
            state_d      = ST_DISP;
          end
          cts_pkg::OP_DELETE: begin
            if (out_free) begin
              out_load       = 1'b1;
              out_d.slot_out = 5'(req_q.slot_index);
              out_d.last     = 1'b1;
              if (slot_bad) begin
                out_d.result_kind     = cts_pkg::RK_BAD_SLOT;
                out_d.task_handle_out = 8'd0;
              end else begin
                out_d.result_kind     = cts_pkg::RK_DELETED;
                out_d.task_handle_out = sel.handle;
                ctrl.cmd              = cts_pkg::CMD_SHIFT;
                count_d               = count_q - CW'(1);
              end
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DISP: begin
        if (scan) begin
          if (sel.pending != 8'd0) begin
            // A run is found; the previous one leaves the hold register first.
            if (!hold_valid_q || out_free) begin
              if (hold_valid_q) begin
                out_load   = 1'b1;
                out_d      = hold_q;
                out_d.last = 1'b0;
              end
              hold_d.result_kind     = cts_pkg::RK_RUN;
              hold_d.task_handle_out = sel.handle;
              hold_d.slot_out        = 5'(pos_q);
              hold_d.last            = 1'b0;
              hold_valid_d           = 1'b1;
              nres_d                 = nres_q + NW'(1);
              if (sel.period == 16'd0) begin
                // One-shot entry: remove it; the cursor stays on the same slot.
                ctrl.cmd = cts_pkg::CMD_SHIFT;
                count_d  = count_q - CW'(1);
              end else begin
                ctrl.cmd = cts_pkg::CMD_DEC;
                pos_d    = pos_q + CW'(1);
              end
            end
          end else begin
            pos_d = pos_q + CW'(1);
          end
        end else if (out_free) begin
          // Walk finished: flush the staged run or report that none ran.
          out_load = 1'b1;
          if (hold_valid_q) begin
            out_d      = hold_q;
            out_d.last = 1'b1;
          end else begin
            out_d.result_kind     = cts_pkg::RK_NONE_READY;
            out_d.task_handle_out = 8'd0;
            out_d.slot_out        = 5'd0;
            out_d.last            = 1'b1;
          end
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid tracking.
  assign out_valid_d = out_load ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      pos_q        <= '0;
      nres_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      nres_q       <= nres_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) req_q <= req_i;
    hold_q <= hold_d;
    if (out_load) out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

### dv/cooperative_task_scheduler_table_top_tb.sv
module cooperative_task_scheduler_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_REQUESTS = 21;

  // Mirror of the task table that predicts the results of each request.
  class run_scoreboard;
    cts_pkg::entry_t slots[cts_pkg::MAX_TASKS_DEF];
    int unsigned     fill;
    cts_pkg::rsp_t   due_results[$];
    int unsigned     mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void queue_result(logic [2:0] kind, logic [7:0] handle, logic [4:0] slot,
                               logic last);
      cts_pkg::rsp_t res;
      res.result_kind = kind;
      res.task_handle_out = handle;
      res.slot_out = slot;
      res.last = last;
      due_results.push_back(res);
    endfunction

    // Removing an entry moves the later ones down and clears the freed last slot.
    function void drop_slot(int unsigned s);
      for (int unsigned i = s; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
      slots[fill] = '0;
    endfunction

    // Apply one accepted request to the table and queue what it should emit.
    function void log_request(cts_pkg::req_t r);
      int unsigned   i;
      int unsigned   runs;
      logic [7:0]    gone;
      cts_pkg::rsp_t tail;
      runs = 0;
      case (r.operation)
        cts_pkg::OP_ADD: begin
          if (fill >= cts_pkg::MAX_TASKS_DEF) begin
            queue_result(cts_pkg::RK_FULL, r.task_handle, 5'(cts_pkg::MAX_TASKS_DEF), 1'b1);
          end else begin
            slots[fill].handle = r.task_handle;
            slots[fill].delay = r.delay_ticks;
            slots[fill].period = r.period_ticks;
            slots[fill].pending = 8'd0;
            queue_result(cts_pkg::RK_ADDED, r.task_handle, 5'(fill), 1'b1);
            fill++;
          end
        end
        cts_pkg::OP_TICK: begin
          for (i = 0; i < fill; i++) begin
            if (slots[i].delay != 16'd0) begin
              slots[i].delay = slots[i].delay - 16'd1;
            end else begin
              slots[i].delay = slots[i].period;
              if (slots[i].pending != 8'hFF) slots[i].pending = slots[i].pending + 8'd1;
            end
          end
        end
        cts_pkg::OP_DISPATCH: begin
          // A one-shot removal keeps the cursor in place so the shifted entry is seen.
          i = 0;
          while (i < fill && runs < cts_pkg::MAX_RESULTS) begin
            if (slots[i].pending != 8'd0) begin
              slots[i].pending = slots[i].pending - 8'd1;
              queue_result(cts_pkg::RK_RUN, slots[i].handle, 5'(i), 1'b0);
              runs++;
              if (slots[i].period == 16'd0) begin
                drop_slot(i);
                continue;
              end
            end
            i++;
          end
          if (runs == 0) begin
            queue_result(cts_pkg::RK_NONE_READY, 8'd0, 5'd0, 1'b1);
          end else begin
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
          end
        end
        cts_pkg::OP_DELETE: begin
          if (r.slot_index >= fill) begin
            queue_result(cts_pkg::RK_BAD_SLOT, 8'd0, 5'(r.slot_index), 1'b1);
          end else begin
            gone = slots[r.slot_index].handle;
            drop_slot(r.slot_index);
            queue_result(cts_pkg::RK_DELETED, gone, 5'(r.slot_index), 1'b1);
          end
        end
      endcase
    endfunction

    function void report(string what, cts_pkg::rsp_t want, cts_pkg::rsp_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected kind %0d handle %0d slot %0d last %0d,",
                 what, want.result_kind, want.task_handle_out, want.slot_out, want.last);
        $display("  got kind %0d handle %0d slot %0d last %0d",
                 got.result_kind, got.task_handle_out, got.slot_out, got.last);
      end
    endfunction

    // Compare one delivered result with the oldest outstanding one.
    function void match_result(cts_pkg::rsp_t got);
      cts_pkg::rsp_t want;
      if (due_results.size() == 0) begin
        report("Unexpected result", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got.result_kind !== want.result_kind
            || got.task_handle_out !== want.task_handle_out
            || got.slot_out !== want.slot_out || got.last !== want.last) begin
          report("Result mismatch", want, got);
        end
      end
    endfunction

    function void flush_leftover();
      while (due_results.size() != 0) begin
        report("Result never arrived", due_results.pop_front(), '0);
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           req_valid = 1'b0;
  cts_pkg::req_t  req_data = '0;
  logic           res_ready = 1'b0;
  logic           req_ready_o;
  logic           res_valid_o;
  cts_pkg::rsp_t  res_o;

  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    quiet_cycles = 0;
  run_scoreboard board;

  always #6 clk_i = ~clk_i;

  cooperative_task_scheduler_table_top #(
    .MAX_TASKS(cts_pkg::MAX_TASKS_DEF)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready_o),
    .req_i(req_data),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready),
    .res_o(res_o)
  );

  // Result side: random stalls, checking, and a watchdog on lack of progress.
  always @(posedge clk_i) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni) begin
      if (res_valid_o && res_ready) board.match_result(res_o);
      if ((res_valid_o && res_ready) || (req_valid && req_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cts_pkg::req_t make_req(logic [1:0] op, logic [7:0] handle,
                                             logic [15:0] delay, logic [15:0] period,
                                             logic [3:0] slot);
    cts_pkg::req_t r;
    r.operation = op;
    r.task_handle = handle;
    r.delay_ticks = delay;
    r.period_ticks = period;
    r.slot_index = slot;
    return r;
  endfunction

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(cts_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    board.log_request(r);
  endtask

  // Random request: mostly short delays and periods so tasks actually come due.
  task automatic send_random_request();
    cts_pkg::req_t r;
    int unsigned   roll;
    r.task_handle = 8'($urandom());
    r.delay_ticks = 16'($urandom());
    r.period_ticks = 16'($urandom());
    r.slot_index = 4'($urandom());
    roll = $urandom_range(99);
    if (roll < 30 && (board.fill < cts_pkg::MAX_TASKS_DEF || $urandom_range(3) == 0)) begin
      r.operation = cts_pkg::OP_ADD;
      if ($urandom_range(4) != 0) begin
        r.delay_ticks = 16'($urandom_range(3));
        r.period_ticks = 16'($urandom_range(4));
      end
    end else if (roll < 62) begin
      r.operation = cts_pkg::OP_TICK;
    end else if (roll < 82) begin
      r.operation = cts_pkg::OP_DISPATCH;
    end else begin
      r.operation = cts_pkg::OP_DELETE;
      if (board.fill > 0 && $urandom_range(4) != 0) begin
        r.slot_index = 4'($urandom_range(board.fill - 1));
      end
    end
    send_request(r);
  endtask

  // Directed sequence: empty table, adjacent one-shots, extreme fields, full table.
  task automatic run_directed();
    send_request(make_req(cts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF));
    send_request(make_req(cts_pkg::OP_ADD, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_ADD, 8'hFF, 16'd0, 16'd0, 4'hF));
    send_request(make_req(cts_pkg::OP_ADD, 8'd1, 16'hFFFF, 16'hFFFF, 4'd0));
    for (int k = 3; k < cts_pkg::MAX_TASKS_DEF; k++) begin
      send_request(make_req(cts_pkg::OP_ADD, 8'(k * 17), 16'(k % 3), 16'(k % 4), 4'd0));
    end
    send_request(make_req(cts_pkg::OP_ADD, 8'hC3, 16'd5, 16'd5, 4'd0));
    send_request(make_req(cts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 4'hF));
    send_request(make_req(cts_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 4'd0));
    send_request(make_req(cts_pkg::OP_DISPATCH, 8'd0, 16'd0, 16'd0, 4'd0));
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random traffic under each idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      repeat (PHASE_REQUESTS) send_random_request();
    end
    req_valid <= 1'b0;

    // Wait for every outstanding result, then let a trailing tick settle.
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.flush_leftover();
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### cooperative_task_scheduler_table_top.f
src/cts_pkg.sv
src/cts_cell.sv
src/cooperative_task_scheduler_table_top.sv
dv/cooperative_task_scheduler_table_top_tb.sv
